FILE: design/rlptfp_pkg.sv
// shared types, codes and constants of the rlp transaction field parser
// no dependencies; used by rlptfp_fsm and rlp_transaction_field_parser_top
package rlptfp_pkg;

  // default width of the length counters
  localparam int unsigned LenBitsDefault = 32;

  // header byte boundaries
  localparam logic [7:0] ListHdrShortMax = 8'hf7;  // 0xf7 and below are not long lists
  localparam logic [7:0] StrShortBase    = 8'h80;
  localparam logic [7:0] StrShortMax     = 8'hb7;  // 0x80 + 0x37
  localparam logic [7:0] StrLongMax      = 8'hbf;
  localparam logic [7:0] AddrHdr         = 8'h94;
  localparam int unsigned AddrBytes      = 20;

  // field counts per layout
  localparam logic [4:0] BlockFields     = 5'd9;
  localparam logic [4:0] ValidatorFields = 5'd5;

  typedef enum logic {
    LAYOUT_BLOCK     = 1'b0,
    LAYOUT_VALIDATOR = 1'b1
  } layout_e;

  typedef enum logic [1:0] {
    FK_INT  = 2'd0,
    FK_ADDR = 2'd1,
    FK_DATA = 2'd2
  } fkind_e;

  typedef enum logic [2:0] {
    KIND_LIST_HDR  = 3'd0,
    KIND_LIST_LEN  = 3'd1,
    KIND_FIELD_HDR = 3'd2,
    KIND_IMMEDIATE = 3'd3,
    KIND_DATA_LEN  = 3'd4,
    KIND_PAYLOAD   = 3'd5,
    KIND_IGNORED   = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_NOT_LIST  = 3'd1,
    ERR_BAD_HDR   = 3'd2,
    ERR_BAD_ADDR  = 3'd3,
    ERR_OVERRUN   = 3'd4,
    ERR_TRUNCATED = 3'd5,
    ERR_TRAILING  = 3'd6
  } err_e;

  // one tagged byte
  typedef struct packed {
    logic [3:0] field_index;
    kind_e      kind;
    logic [7:0] data;
    logic       field_last;
    err_e       error;
    logic       frame_done;
  } result_t;

  // field format at a given position of a layout
  function automatic fkind_e field_kind(input layout_e layout, input logic [3:0] pos);
    fkind_e fk;
    fk = FK_INT;
    case (layout)
      LAYOUT_BLOCK: begin
        if (pos == 4'd3) begin
          fk = FK_ADDR;
        end else if (pos == 4'd5) begin
          fk = FK_DATA;
        end
      end
      LAYOUT_VALIDATOR: begin
        if (pos == 4'd0) begin
          fk = FK_DATA;
        end
      end
      default: fk = FK_INT;
    endcase
    return fk;
  endfunction

  function automatic logic [4:0] field_count(input layout_e layout);
    return (layout == LAYOUT_VALIDATOR) ? ValidatorFields : BlockFields;
  endfunction

endpackage

FILE: design/rlp_transaction_field_parser_top.sv
// top level of the rlp transaction field parser: handshakes, input stage, layout register
// depends on rlptfp_pkg and rlptfp_fsm
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------------------
//   in      | input     | in_valid_i / in_stall_o | in_byte_i, frame_end_i
//   out     | output    | out_valid_o / out_stall_i | field_index_o, byte_kind_o, payload_byte_o,
//           |           |                        | field_last_o, error_code_o, frame_done_o
//   cfg     | input     | layout_we_i            | layout_wdata_i
//
// one request in and one request out per cycle, sustained while out_stall_i is low; each byte
// passes the input register, then the parser decode into the result register
// the per-byte decode and counter update in rlptfp_fsm is the one step per byte
// rst_ni clears the parser state, the layout register and both valid flags
// the input stage keeps taking requests while the result register drains; a stalled
// output backs up into in_stall_o only when both stages are full
module rlp_transaction_field_parser_top #(
  parameter int unsigned LENGTH_BITS = rlptfp_pkg::LenBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input byte channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       frame_end_i,
  // layout register write
  input  logic       layout_we_i,
  input  logic       layout_wdata_i,
  // tagged byte channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] field_index_o,
  output logic [2:0] byte_kind_o,
  output logic [7:0] payload_byte_o,
  output logic       field_last_o,
  output logic [2:0] error_code_o,
  output logic       frame_done_o
);

  rlptfp_pkg::layout_e  layout_q;
  logic                 in_valid_q;
  logic [7:0]           in_byte_q;
  logic                 frame_end_q;
  logic                 out_valid_q;
  logic                 step;
  logic                 in_take;
  rlptfp_pkg::result_t  result;

  // input stage moves into the result register when that register is free or draining
  assign step       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !step;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layout_q    <= rlptfp_pkg::LAYOUT_BLOCK;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (layout_we_i) begin
        layout_q <= rlptfp_pkg::layout_e'(layout_wdata_i);
      end
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (step) begin
        in_valid_q <= 1'b0;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // input payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q   <= in_byte_i;
      frame_end_q <= frame_end_i;
    end
  end

  // header decode, counters and result register
  rlptfp_fsm #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .in_byte_i   (in_byte_q),
    .frame_end_i (frame_end_q),
    .layout_i    (layout_q),
    .result_o    (result)
  );

  assign out_valid_o    = out_valid_q;
  assign field_index_o  = result.field_index;
  assign byte_kind_o    = result.kind;
  assign payload_byte_o = result.data;
  assign field_last_o   = result.field_last;
  assign error_code_o   = result.error;
  assign frame_done_o   = result.frame_done;

endmodule

FILE: design/rlptfp_fsm.sv
// parser state machine: per-byte header decode, counters and result register
// depends on rlptfp_pkg
module rlptfp_fsm #(
  parameter int unsigned LENGTH_BITS = rlptfp_pkg::LenBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           in_byte_i,
  input  logic                 frame_end_i,
  input  rlptfp_pkg::layout_e  layout_i,
  output rlptfp_pkg::result_t  result_o
);

  typedef enum logic [2:0] {
    PH_LIST_HDR  = 3'd0,
    PH_LIST_LEN  = 3'd1,
    PH_FIELD_HDR = 3'd2,
    PH_DATA_LEN  = 3'd3,
    PH_PAYLOAD   = 3'd4,
    PH_DONE      = 3'd5
  } phase_e;

  typedef logic [LENGTH_BITS-1:0] len_t;

  // big-endian length build-up, saturating
  function automatic len_t len_push(input len_t acc, input logic [7:0] b);
    len_t r;
    if (|acc[LENGTH_BITS-1 -: 8]) begin
      r = '1;
    end else begin
      r = {acc[LENGTH_BITS-9:0], b};
    end
    return r;
  endfunction

  phase_e               phase_q, phase_d;
  logic [3:0]           pos_q, pos_d;
  len_t                 remain_q, remain_d;
  logic [3:0]           lenleft_q, lenleft_d;
  len_t                 decl_q, decl_d;
  len_t                 seen_q, seen_d;
  rlptfp_pkg::err_e     err_q, err_d;
  rlptfp_pkg::result_t  result_q, result_d;

  rlptfp_pkg::kind_e    kind;
  rlptfp_pkg::fkind_e   fk;
  logic                 finish;

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    remain_d  = remain_q;
    lenleft_d = lenleft_q;
    decl_d    = decl_q;
    seen_d    = seen_q;
    err_d     = err_q;
    kind      = rlptfp_pkg::KIND_IGNORED;
    finish    = 1'b0;
    fk        = rlptfp_pkg::field_kind(layout_i, pos_q);

    if (err_q == rlptfp_pkg::ERR_NONE) begin
      unique case (phase_q)
        PH_LIST_HDR: begin
          kind = rlptfp_pkg::KIND_LIST_HDR;
          if (in_byte_i <= rlptfp_pkg::ListHdrShortMax) begin
            err_d = rlptfp_pkg::ERR_NOT_LIST;
          end else begin
            lenleft_d = in_byte_i[3:0] - 4'd7;
            decl_d    = '0;
            phase_d   = PH_LIST_LEN;
          end
        end
        PH_LIST_LEN: begin
          kind      = rlptfp_pkg::KIND_LIST_LEN;
          decl_d    = len_push(decl_q, in_byte_i);
          lenleft_d = lenleft_q - 4'd1;
          if (lenleft_d == 4'd0) begin
            pos_d   = '0;
            seen_d  = '0;
            phase_d = PH_FIELD_HDR;
          end
        end
        PH_DONE: begin
          err_d = rlptfp_pkg::ERR_TRAILING;
        end
        default: begin
          if (seen_q >= decl_q) begin
            err_d = rlptfp_pkg::ERR_OVERRUN;
          end else begin
            seen_d = seen_q + len_t'(1);
            if (phase_q == PH_PAYLOAD) begin
              kind     = rlptfp_pkg::KIND_PAYLOAD;
              remain_d = remain_q - len_t'(1);
              finish   = (remain_d == '0);
            end else if (phase_q == PH_DATA_LEN) begin
              kind      = rlptfp_pkg::KIND_DATA_LEN;
              remain_d  = len_push(remain_q, in_byte_i);
              lenleft_d = lenleft_q - 4'd1;
              if (lenleft_d == 4'd0) begin
                if (remain_d == '0) begin
                  finish = 1'b1;
                end else begin
                  phase_d = PH_PAYLOAD;
                end
              end
            end else begin
              kind = rlptfp_pkg::KIND_FIELD_HDR;
              if (fk == rlptfp_pkg::FK_ADDR) begin
                if (in_byte_i != rlptfp_pkg::AddrHdr) begin
                  err_d = rlptfp_pkg::ERR_BAD_ADDR;
                end else begin
                  remain_d = len_t'(rlptfp_pkg::AddrBytes);
                  phase_d  = PH_PAYLOAD;
                end
              end else if (in_byte_i < rlptfp_pkg::StrShortBase) begin
                kind   = rlptfp_pkg::KIND_IMMEDIATE;
                finish = 1'b1;
              end else if (in_byte_i <= rlptfp_pkg::StrShortMax) begin
                // short string, 0xb7 counts as short
                remain_d = len_t'(in_byte_i[6:0]);
                if (in_byte_i == rlptfp_pkg::StrShortBase) begin
                  finish = 1'b1;
                end else begin
                  phase_d = PH_PAYLOAD;
                end
              end else if (fk == rlptfp_pkg::FK_DATA && in_byte_i <= rlptfp_pkg::StrLongMax) begin
                lenleft_d = in_byte_i[3:0] - 4'd7;
                remain_d  = '0;
                phase_d   = PH_DATA_LEN;
              end else begin
                err_d = rlptfp_pkg::ERR_BAD_HDR;
              end
            end
          end
        end
      endcase
    end

    // field complete: next field or schema done
    if (finish) begin
      if (({1'b0, pos_q} + 5'd1) >= rlptfp_pkg::field_count(layout_i)) begin
        phase_d = PH_DONE;
      end else begin
        pos_d   = pos_q + 4'd1;
        phase_d = PH_FIELD_HDR;
      end
    end

    if (frame_end_i && err_d == rlptfp_pkg::ERR_NONE &&
        !(phase_d == PH_DONE && seen_d == decl_d)) begin
      err_d = rlptfp_pkg::ERR_TRUNCATED;
    end

    result_d.field_index = (phase_d == PH_LIST_HDR || phase_d == PH_LIST_LEN) ? 4'd0 : pos_d;
    result_d.kind        = kind;
    result_d.data        = in_byte_i;
    result_d.field_last  = finish;
    result_d.error       = err_d;
    result_d.frame_done  = frame_end_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_LIST_HDR;
      pos_q     <= '0;
      remain_q  <= '0;
      lenleft_q <= '0;
      decl_q    <= '0;
      seen_q    <= '0;
      err_q     <= rlptfp_pkg::ERR_NONE;
      result_q  <= '0;
    end else if (step_i) begin
      result_q <= result_d;
      if (frame_end_i) begin
        phase_q   <= PH_LIST_HDR;
        pos_q     <= '0;
        remain_q  <= '0;
        lenleft_q <= '0;
        decl_q    <= '0;
        seen_q    <= '0;
        err_q     <= rlptfp_pkg::ERR_NONE;
      end else begin
        phase_q   <= phase_d;
        pos_q     <= pos_d;
        remain_q  <= remain_d;
        lenleft_q <= lenleft_d;
        decl_q    <= decl_d;
        seen_q    <= seen_d;
        err_q     <= err_d;
      end
    end
  end

  assign result_o = result_q;

endmodule
